// ----- rtl/pcrc_pkg.sv -----
// shared types, constants and the crc-8 byte function for the packet crc checker
// no dependencies
`timescale 1ns / 1ps

package pcrc_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_TYPES   = 8;
    localparam int TYPE_W      = 3;
    localparam int TYPE_LSB    = 5;
    localparam int ATT_W       = 5;
    localparam int MS_W        = 16;
    localparam int SHIFT_W     = MS_W + (1 << ATT_W) - 1;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_INIT = 8'h00;

    localparam logic [ATT_W-1:0] ATT_MAX = '1;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    // register indexes of the config port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_EN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NO_ACK_TYPE   = 3'd4;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        logic              ack_en;
        logic [MS_W-1:0]   timeout_ms;
        logic [3:0]        max_attempts;
        logic [MS_W-1:0]   backoff_base_ms;
        logic [TYPE_W-1:0] no_ack_type;
    } t_cfg;

    typedef struct packed {
        logic            send_ping;
        logic            ping_for_recovery;
        logic            flush_rx;
        logic [MS_W-1:0] backoff;
        logic            recovery_failed;
        logic            recovery_done;
    } t_rec_out;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/packet_crc_check_and_recovery.sv -----
// top level: input word register, crc-8 check, counters, recovery, result register
// depends on pcrc_pkg, pcrc_counters, pcrc_recovery
`timescale 1ns / 1ps
//
//  channel   direction  signals                                 width
//  s_axis    in         s_axis_tvalid/tready/tdata              32
//  m_axis    out        m_axis_tvalid/tready/tdata              72
//  cfg       in         i_cfg_valid/o_cfg_ready/index/data      3 + 16
//
//  one packet per cycle while the result is not stalled; the result word is registered
//  the crc, counter increment and recovery update all sit between the input
//  word register and the result register
//  a stalled result holds both registers; s_axis_tready drops only when both are full
//  synchronous active-low reset clears counters, recovery state and config to defaults

module packet_crc_check_and_recovery (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // header_byte[7:0], payload_first[15:8], payload_second[23:16], received_crc[31:24]
    input  logic [pcrc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // packet_type[2:0], crc_ok[3], computed_crc[11:4], type_count[43:12],
    // send_ping[44], ping_for_recovery[45], flush_rx[46], backoff[62:47],
    // recovery_failed[63], recovery_done[64], zero[71:65]
    output logic [pcrc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pcrc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pcrc_pkg::MS_W-1:0]            i_cfg_data
);

    pcrc_pkg::t_cfg                     r_cfg;
    logic                               r_in_valid;
    logic [pcrc_pkg::IN_DATA_W-1:0]     r_in;
    logic                               r_out_valid;
    logic [pcrc_pkg::OUT_DATA_W-1:0]    r_out;
    logic [pcrc_pkg::OUT_DATA_W-1:0]    n_out;

    logic                               w_adv;
    logic [pcrc_pkg::TYPE_W-1:0]        w_type;
    logic [7:0]                         w_crc;
    logic                               w_ok;
    logic [31:0]                        w_count;
    pcrc_pkg::t_rec_out                 w_rec;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign o_cfg_ready   = 1'b1;

    assign w_type = r_in[pcrc_pkg::TYPE_LSB +: pcrc_pkg::TYPE_W];
    assign w_crc  = pcrc_pkg::crc8_byte(pcrc_pkg::crc8_byte(
                        pcrc_pkg::crc8_byte(pcrc_pkg::CRC_INIT, r_in[7:0]),
                        r_in[15:8]), r_in[23:16]);
    assign w_ok   = (w_crc == r_in[31:24]);

    pcrc_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_inc   (w_adv),
        .i_type  (w_type),
        .o_count (w_count)
    );

    pcrc_recovery u_recovery (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_crc_ok (w_ok),
        .i_type   (w_type),
        .i_cfg    (r_cfg),
        .o_res    (w_rec)
    );

    assign n_out = {7'd0, w_rec.recovery_done, w_rec.recovery_failed, w_rec.backoff,
                    w_rec.flush_rx, w_rec.ping_for_recovery, w_rec.send_ping,
                    w_count, w_crc, w_ok, w_type};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ack_en          <= 1'b0;
            r_cfg.timeout_ms      <= 16'd1000;
            r_cfg.max_attempts    <= 4'd3;
            r_cfg.backoff_base_ms <= 16'd100;
            r_cfg.no_ack_type     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pcrc_pkg::REG_ACK_EN:       r_cfg.ack_en          <= i_cfg_data[0];
                pcrc_pkg::REG_TIMEOUT_MS:   r_cfg.timeout_ms      <= i_cfg_data;
                pcrc_pkg::REG_MAX_ATTEMPTS: r_cfg.max_attempts    <= i_cfg_data[3:0];
                pcrc_pkg::REG_BACKOFF_BASE: r_cfg.backoff_base_ms <= i_cfg_data;
                pcrc_pkg::REG_NO_ACK_TYPE:  r_cfg.no_ack_type     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= s_axis_tdata;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- rtl/pcrc_counters.sv -----
// per-type wrapping packet counters, one increment per packet
// depends on pcrc_pkg
`timescale 1ns / 1ps

module pcrc_counters (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_inc,
    input  logic [pcrc_pkg::TYPE_W-1:0] i_type,
    output logic [31:0]                o_count
);

    pcrc_pkg::t_count r_cnt [pcrc_pkg::NUM_TYPES];
    pcrc_pkg::t_count n_cnt;
    logic [63:0]      w_wide;

    assign n_cnt   = r_cnt[i_type] + pcrc_pkg::t_count'(1);
    assign w_wide  = 64'(n_cnt);
    assign o_count = w_wide[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pcrc_pkg::NUM_TYPES; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_inc) begin
            r_cnt[i_type] <= n_cnt;
        end
    end

endmodule

// ----- rtl/pcrc_recovery.sv -----
// recovery state, attempt counting, backoff and ping decisions
// depends on pcrc_pkg
`timescale 1ns / 1ps

module pcrc_recovery (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_crc_ok,
    input  logic [pcrc_pkg::TYPE_W-1:0] i_type,
    input  pcrc_pkg::t_cfg              i_cfg,
    output pcrc_pkg::t_rec_out          o_res
);

    logic                              r_recovering;
    logic [pcrc_pkg::ATT_W-1:0]        r_attempt;
    logic                              n_recovering;
    logic [pcrc_pkg::ATT_W-1:0]        n_attempt;
    logic [pcrc_pkg::ATT_W-1:0]        w_att_inc;
    logic [pcrc_pkg::ATT_W-1:0]        w_shift;
    logic [pcrc_pkg::SHIFT_W-1:0]      w_shifted;
    logic [pcrc_pkg::MS_W-1:0]         w_backoff;
    logic                              w_over;

    assign w_att_inc = (r_attempt < pcrc_pkg::ATT_MAX) ? r_attempt + 1'b1 : r_attempt;
    assign w_over    = w_att_inc > {1'b0, i_cfg.max_attempts};
    assign w_shift   = w_att_inc - 1'b1;
    assign w_shifted = pcrc_pkg::SHIFT_W'(i_cfg.backoff_base_ms) << w_shift;
    assign w_backoff = (w_shifted > pcrc_pkg::SHIFT_W'(i_cfg.timeout_ms)) ?
                       i_cfg.timeout_ms : w_shifted[pcrc_pkg::MS_W-1:0];

    always_comb begin
        n_recovering = r_recovering;
        n_attempt    = r_attempt;
        o_res        = '0;
        if (!i_crc_ok) begin
            if (!r_recovering) begin
                if (w_over) begin
                    n_recovering          = 1'b0;
                    n_attempt             = '0;
                    o_res.recovery_failed = 1'b1;
                end else begin
                    n_recovering            = 1'b1;
                    n_attempt               = w_att_inc;
                    o_res.flush_rx          = 1'b1;
                    o_res.send_ping         = 1'b1;
                    o_res.ping_for_recovery = 1'b1;
                    o_res.backoff           = w_backoff;
                end
            end
        end else begin
            o_res.send_ping = i_cfg.ack_en && (i_type != i_cfg.no_ack_type);
            if (r_recovering) begin
                n_recovering        = 1'b0;
                n_attempt           = '0;
                o_res.recovery_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recovering <= 1'b0;
            r_attempt    <= '0;
        end else if (i_step) begin
            r_recovering <= n_recovering;
            r_attempt    <= n_attempt;
        end
    end

endmodule
